[src/kmp_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package kmp_pkg;

  // Sizing of the pattern stores.
  localparam int MAX_PATTERN = 64;
  localparam int SYMBOL_BITS = 8;
  localparam int IDX_BITS    = $clog2(MAX_PATTERN);
  localparam int LEN_BITS    = $clog2(MAX_PATTERN + 1);

  // Operation carried by each input word.
  typedef enum logic [1:0] {
    FUNC_CLEAR  = 2'd0,
    FUNC_APPEND = 2'd1,
    FUNC_TEXT   = 2'd2,
    FUNC_SEARCH = 2'd3
  } func_e;

  // Status reported with each result word.
  typedef enum logic [1:0] {
    STAT_OK    = 2'd0,
    STAT_FULL  = 2'd1,
    STAT_EMPTY = 2'd2
  } status_e;

  // Controller states.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOAD,
    ST_WALK
  } ctrl_state_e;

  typedef struct packed {
    func_e                  func;
    logic [SYMBOL_BITS-1:0] symbol;
  } in_word_t;

  typedef struct packed {
    logic                match_now;
    logic                found;
    logic [LEN_BITS-1:0] pattern_length;
    status_e             status;
  } out_word_t;

endpackage

`default_nettype wire

[src/kmp_stream_matcher_top.sv]
`timescale 1ns / 1ps
`default_nettype none

// Streaming Knuth-Morris-Pratt matcher. Each input word either clears the
// pattern, appends a pattern symbol, scans a text symbol or starts a new
// search, and yields exactly one result word. The pattern and its prefix
// function live in two 64-entry memories with a registered read; every step
// of a failure walk costs one memory read. Clear, new search, refused or
// ignored words and the first append are answered without a memory read; a
// text symbol starts its walk at once, and a later append first reads the
// prefix entry of the last symbol and then walks. Over a text stream the
// failure steps stay below one per symbol on average. The result sits in an
// output register, and a new word is accepted only when the sequencer is idle
// and that register is empty or is being emptied in the same cycle, so a
// result that is still waiting holds off the input.
module kmp_stream_matcher_top (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output      logic               in_ready_o,
  input  wire kmp_pkg::in_word_t  in_word_i,
  output      logic               out_valid_o,
  input  wire logic               out_ready_i,
  output      kmp_pkg::out_word_t out_word_o
);

  logic                            out_valid_q, out_valid_d;
  kmp_pkg::out_word_t              out_word_q, out_word_d;
  logic                            out_free;
  logic                            res_valid;
  kmp_pkg::out_word_t              res_word;
  logic                            mem_we;
  logic [kmp_pkg::IDX_BITS-1:0]    mem_waddr;
  logic [kmp_pkg::SYMBOL_BITS-1:0] pat_wdata;
  logic [kmp_pkg::LEN_BITS-1:0]    pre_wdata;
  logic [kmp_pkg::IDX_BITS-1:0]    pat_raddr;
  logic [kmp_pkg::IDX_BITS-1:0]    pre_raddr;
  logic [kmp_pkg::SYMBOL_BITS-1:0] pat_rdata;
  logic [kmp_pkg::LEN_BITS-1:0]    pre_rdata;

  // The output register has room if it is empty or being emptied now.
  assign out_free = !out_valid_q || out_ready_i;

  kmp_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_word_i   (in_word_i),
    .out_free_i  (out_free),
    .res_valid_o (res_valid),
    .res_word_o  (res_word),
    .mem_we_o    (mem_we),
    .mem_waddr_o (mem_waddr),
    .pat_wdata_o (pat_wdata),
    .pre_wdata_o (pre_wdata),
    .pat_raddr_o (pat_raddr),
    .pre_raddr_o (pre_raddr),
    .pat_rdata_i (pat_rdata),
    .pre_rdata_i (pre_rdata)
  );

  // Pattern symbols.
  kmp_ram #(
    .WIDTH (kmp_pkg::SYMBOL_BITS),
    .DEPTH (kmp_pkg::MAX_PATTERN)
  ) u_pat_ram (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (pat_wdata),
    .raddr_i (pat_raddr),
    .rdata_o (pat_rdata)
  );

  // Prefix function entries.
  kmp_ram #(
    .WIDTH (kmp_pkg::LEN_BITS),
    .DEPTH (kmp_pkg::MAX_PATTERN)
  ) u_pre_ram (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (pre_wdata),
    .raddr_i (pre_raddr),
    .rdata_o (pre_rdata)
  );

  // Output register.
  always_comb begin
    out_valid_d = out_valid_q;
    out_word_d  = out_word_q;
    if (res_valid) begin
      out_valid_d = 1'b1;
      out_word_d  = res_word;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_word_q <= out_word_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_word_q;

endmodule

`default_nettype wire

[src/kmp_ram.sv]
`timescale 1ns / 1ps
`default_nettype none

// Simple dual-port RAM: one write port, one read port with registered data.
module kmp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output      logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port.
  always_ff @(posedge clk_i) begin
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

[src/kmp_ctrl.sv]
`timescale 1ns / 1ps
`default_nettype none

// Sequencer for the matcher: takes one word, walks the failure chain through
// the pattern and prefix memories, and writes back on an append.
module kmp_ctrl (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         in_valid_i,
  output      logic                         in_ready_o,
  input  wire kmp_pkg::in_word_t            in_word_i,
  input  wire logic                         out_free_i,
  output      logic                         res_valid_o,
  output      kmp_pkg::out_word_t           res_word_o,
  output      logic                         mem_we_o,
  output      logic [kmp_pkg::IDX_BITS-1:0] mem_waddr_o,
  output      logic [kmp_pkg::SYMBOL_BITS-1:0] pat_wdata_o,
  output      logic [kmp_pkg::LEN_BITS-1:0] pre_wdata_o,
  output      logic [kmp_pkg::IDX_BITS-1:0] pat_raddr_o,
  output      logic [kmp_pkg::IDX_BITS-1:0] pre_raddr_o,
  input  wire logic [kmp_pkg::SYMBOL_BITS-1:0] pat_rdata_i,
  input  wire logic [kmp_pkg::LEN_BITS-1:0] pre_rdata_i
);

  kmp_pkg::ctrl_state_e                state_q, state_d;
  logic [kmp_pkg::LEN_BITS-1:0]        len_q, len_d;
  logic [kmp_pkg::LEN_BITS-1:0]        matched_q, matched_d;
  logic                                found_q, found_d;
  logic                                is_append_q, is_append_d;
  logic [kmp_pkg::IDX_BITS-1:0]        m_q, m_d;
  logic [kmp_pkg::SYMBOL_BITS-1:0]     sym_q, sym_d;

  logic                                accept;
  logic                                pat_hit;
  logic                                fail_step;
  logic [kmp_pkg::LEN_BITS-1:0]        m_ext;
  logic [kmp_pkg::IDX_BITS-1:0]        m_back;
  logic [kmp_pkg::LEN_BITS-1:0]        walk_res;
  logic [kmp_pkg::IDX_BITS-1:0]        text_start;
  logic [kmp_pkg::IDX_BITS-1:0]        load_m;

  // A new word is taken only when the sequencer is free and the output
  // register will have room for its result.
  assign in_ready_o = (state_q == kmp_pkg::ST_IDLE) && out_free_i;
  assign accept     = in_valid_i && in_ready_o;

  // Evaluation of one step of the failure walk on the returned memory data.
  assign pat_hit   = (pat_rdata_i == sym_q);
  assign m_ext     = {1'b0, m_q};
  assign fail_step = (m_q != '0) && !pat_hit;
  assign m_back    = (pre_rdata_i < m_ext) ? pre_rdata_i[kmp_pkg::IDX_BITS-1:0] : '0;
  assign walk_res  = m_ext + kmp_pkg::LEN_BITS'(pat_hit);

  // A text scan restarts from zero if the count has reached the length.
  assign text_start = (matched_q >= len_q) ? '0 : matched_q[kmp_pkg::IDX_BITS-1:0];
  assign load_m     = pre_rdata_i[kmp_pkg::IDX_BITS-1:0];

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      kmp_pkg::ST_IDLE: begin
        if (accept) begin
          if (in_word_i.func == kmp_pkg::FUNC_APPEND &&
              len_q < kmp_pkg::LEN_BITS'(kmp_pkg::MAX_PATTERN) && len_q != '0) begin
            state_d = kmp_pkg::ST_LOAD;
          end else if (in_word_i.func == kmp_pkg::FUNC_TEXT &&
                       len_q != '0 && !found_q) begin
            state_d = kmp_pkg::ST_WALK;
          end
        end
      end
      kmp_pkg::ST_LOAD: begin
        state_d = kmp_pkg::ST_WALK;
      end
      kmp_pkg::ST_WALK: begin
        if (!fail_step) begin
          state_d = kmp_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = kmp_pkg::ST_IDLE;
      end
    endcase
  end

  // Datapath, memory accesses and result.
  always_comb begin
    len_d       = len_q;
    matched_d   = matched_q;
    found_d     = found_q;
    is_append_d = is_append_q;
    m_d         = m_q;
    sym_d       = sym_q;
    mem_we_o    = 1'b0;
    mem_waddr_o = len_q[kmp_pkg::IDX_BITS-1:0];
    pat_wdata_o = sym_q;
    pre_wdata_o = walk_res;
    pat_raddr_o = m_q;
    pre_raddr_o = m_q - kmp_pkg::IDX_BITS'(1);
    res_valid_o = 1'b0;
    res_word_o.match_now = 1'b0;
    res_word_o.status    = kmp_pkg::STAT_OK;

    unique case (state_q)
      kmp_pkg::ST_IDLE: begin
        if (accept) begin
          sym_d = in_word_i.symbol;
          unique case (in_word_i.func)
            kmp_pkg::FUNC_CLEAR: begin
              len_d       = '0;
              matched_d   = '0;
              found_d     = 1'b0;
              res_valid_o = 1'b1;
            end
            kmp_pkg::FUNC_APPEND: begin
              if (len_q >= kmp_pkg::LEN_BITS'(kmp_pkg::MAX_PATTERN)) begin
                res_word_o.status = kmp_pkg::STAT_FULL;
                res_valid_o       = 1'b1;
              end else if (len_q == '0) begin
                // The first symbol has an empty proper border.
                mem_we_o    = 1'b1;
                mem_waddr_o = '0;
                pat_wdata_o = in_word_i.symbol;
                pre_wdata_o = '0;
                len_d       = kmp_pkg::LEN_BITS'(1);
                res_valid_o = 1'b1;
              end else begin
                is_append_d = 1'b1;
                pre_raddr_o = len_q[kmp_pkg::IDX_BITS-1:0] - kmp_pkg::IDX_BITS'(1);
              end
            end
            kmp_pkg::FUNC_TEXT: begin
              if (len_q == '0) begin
                res_word_o.status = kmp_pkg::STAT_EMPTY;
                res_valid_o       = 1'b1;
              end else if (found_q) begin
                res_valid_o = 1'b1;
              end else begin
                is_append_d = 1'b0;
                m_d         = text_start;
                pat_raddr_o = text_start;
                pre_raddr_o = text_start - kmp_pkg::IDX_BITS'(1);
              end
            end
            kmp_pkg::FUNC_SEARCH: begin
              matched_d   = '0;
              found_d     = 1'b0;
              res_valid_o = 1'b1;
            end
            default: begin
              res_valid_o = 1'b1;
            end
          endcase
        end
      end
      kmp_pkg::ST_LOAD: begin
        // Start the walk from the border of the last loaded symbol.
        m_d         = load_m;
        pat_raddr_o = load_m;
        pre_raddr_o = load_m - kmp_pkg::IDX_BITS'(1);
      end
      kmp_pkg::ST_WALK: begin
        if (fail_step) begin
          m_d         = m_back;
          pat_raddr_o = m_back;
          pre_raddr_o = m_back - kmp_pkg::IDX_BITS'(1);
        end else begin
          res_valid_o = 1'b1;
          if (is_append_q) begin
            mem_we_o    = 1'b1;
            mem_waddr_o = len_q[kmp_pkg::IDX_BITS-1:0];
            len_d       = len_q + kmp_pkg::LEN_BITS'(1);
          end else begin
            matched_d = walk_res;
            if (walk_res >= len_q) begin
              found_d              = 1'b1;
              res_word_o.match_now = 1'b1;
            end
          end
        end
      end
      default: begin
      end
    endcase

    res_word_o.found          = found_d;
    res_word_o.pattern_length = len_d;
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= kmp_pkg::ST_IDLE;
      len_q     <= '0;
      matched_q <= '0;
      found_q   <= 1'b0;
    end else begin
      state_q   <= state_d;
      len_q     <= len_d;
      matched_q <= matched_d;
      found_q   <= found_d;
    end
  end

  // Working registers of the current word.
  always_ff @(posedge clk_i) begin
    is_append_q <= is_append_d;
    m_q         <= m_d;
    sym_q       <= sym_d;
  end

endmodule

`default_nettype wire

[tb/kmp_stream_matcher_top_test.sv]
`timescale 1ns / 1ps

module kmp_stream_matcher_top_test;
  import kmp_pkg::*;

  localparam int WATCHDOG_CYCLES = 3000;
  localparam int DRAIN_CYCLES    = 150;
  localparam int WORD_TARGET     = 825;
  localparam int REPORT_LIMIT    = 10;

  typedef struct {
    func_e     func;
    logic [7:0] symbol;
    bit        typed;
    out_word_t want;
  } dir_row_t;

  logic      clk_i;
  logic      rst_ni;
  logic      in_valid_i;
  logic      in_ready_o;
  in_word_t  in_word_i;
  logic      out_valid_o;
  logic      out_ready_i;
  out_word_t out_word_o;

  // Shadow copy of the matcher state.
  logic [SYMBOL_BITS-1:0] pattern_syms [MAX_PATTERN];
  logic [LEN_BITS-1:0]    prefix_lens  [MAX_PATTERN];
  logic [LEN_BITS-1:0]    loaded_len = '0;
  logic [LEN_BITS-1:0]    match_len  = '0;
  logic                   found_seen = 1'b0;

  out_word_t pending_results [$];
  int        err_cnt        = 0;
  int        words_sent     = 0;
  int        send_idle_pct  = 30;
  int        recv_idle_pct  = 54;
  int        stall_cycles   = 0;
  bit        cur_typed      = 1'b0;
  out_word_t cur_want;

  kmp_stream_matcher_top dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_word_i   (in_word_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_word_o  (out_word_o)
  );

  // Free-running clock.
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic logic [SYMBOL_BITS-1:0] sym_at(logic [LEN_BITS-1:0] idx);
    return (idx < LEN_BITS'(MAX_PATTERN)) ? pattern_syms[idx[IDX_BITS-1:0]] : '0;
  endfunction

  function automatic logic [LEN_BITS-1:0] prefix_at(logic [LEN_BITS-1:0] idx);
    return (idx < LEN_BITS'(MAX_PATTERN)) ? prefix_lens[idx[IDX_BITS-1:0]] : '0;
  endfunction

  // Extends a matched length by one symbol, following the failure links.
  function automatic logic [LEN_BITS-1:0] kmp_extend(logic [LEN_BITS-1:0] m_in,
                                                     logic [SYMBOL_BITS-1:0] s);
    logic [LEN_BITS-1:0] m;
    logic [LEN_BITS-1:0] nx;
    int                  guard;
    m     = m_in;
    guard = 0;
    while (m > 0 && sym_at(m) != s && guard < MAX_PATTERN) begin
      nx = prefix_at(m - 1'b1);
      m  = (nx < m) ? nx : '0;
      guard++;
    end
    if (sym_at(m) == s) m = m + 1'b1;
    return m;
  endfunction

  // Applies one accepted word to the shadow state and returns its result.
  task automatic predict_step(input in_word_t w, output out_word_t r);
    logic [LEN_BITS-1:0] entry;
    logic [LEN_BITS-1:0] m;
    r = '{match_now: 1'b0, found: 1'b0, pattern_length: '0, status: STAT_OK};
    case (w.func)
      FUNC_CLEAR: begin
        loaded_len = '0;
        match_len  = '0;
        found_seen = 1'b0;
      end
      FUNC_APPEND: begin
        if (loaded_len >= LEN_BITS'(MAX_PATTERN)) begin
          r.status = STAT_FULL;
        end else begin
          entry = '0;
          if (loaded_len > 0) entry = kmp_extend(prefix_at(loaded_len - 1'b1), w.symbol);
          pattern_syms[loaded_len[IDX_BITS-1:0]] = w.symbol;
          prefix_lens[loaded_len[IDX_BITS-1:0]]  = entry;
          loaded_len = loaded_len + 1'b1;
        end
      end
      FUNC_TEXT: begin
        if (loaded_len == 0) begin
          r.status = STAT_EMPTY;
        end else if (!found_seen) begin
          m = match_len;
          if (m >= loaded_len) m = '0;
          m = kmp_extend(m, w.symbol);
          match_len = m;
          if (m >= loaded_len) begin
            found_seen  = 1'b1;
            r.match_now = 1'b1;
          end
        end
      end
      default: begin
        match_len  = '0;
        found_seen = 1'b0;
      end
    endcase
    r.found          = found_seen;
    r.pattern_length = loaded_len;
  endtask

  // Result check first, then record the expectation of any word taken this edge.
  always @(posedge clk_i) begin
    out_word_t want;
    out_word_t pred;
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        if (pending_results.size() == 0) begin
          err_cnt++;
          if (err_cnt <= REPORT_LIMIT)
            $display("unexpected result word: match_now=%0d found=%0d len=%0d status=%0d",
                     out_word_o.match_now, out_word_o.found,
                     out_word_o.pattern_length, out_word_o.status);
        end else begin
          want = pending_results.pop_front();
          if (out_word_o.match_now !== want.match_now || out_word_o.found !== want.found ||
              out_word_o.pattern_length !== want.pattern_length ||
              out_word_o.status !== want.status) begin
            err_cnt++;
            if (err_cnt <= REPORT_LIMIT)
              $display("mismatch: exp match_now=%0d found=%0d len=%0d status=%0d, got %0d %0d %0d %0d",
                       want.match_now, want.found, want.pattern_length, want.status,
                       out_word_o.match_now, out_word_o.found,
                       out_word_o.pattern_length, out_word_o.status);
          end
        end
      end
      if (in_valid_i && in_ready_o) begin
        predict_step(in_word_i, pred);
        pending_results.push_back(cur_typed ? cur_want : pred);
      end
    end
  end

  // Watchdog on cycles in which neither channel moves a word.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
        stall_cycles <= 0;
      end else if (stall_cycles + 1 >= WATCHDOG_CYCLES) begin
        $display("DONE: errors detected");
        $finish;
      end else begin
        stall_cycles <= stall_cycles + 1;
      end
    end
  end

  // Receiver back-pressure.
  always @(negedge clk_i) begin
    if (rst_ni) out_ready_i <= ($urandom_range(0, 99) >= recv_idle_pct);
  end

  // Offers one word, with random gaps beforehand, and returns after it is taken.
  task automatic send_word(input func_e f, input logic [7:0] s, input bit typed,
                           input out_word_t want);
    if (words_sent < 280) begin
      send_idle_pct = 30;
      recv_idle_pct = 54;
    end else if (words_sent < 560) begin
      send_idle_pct = 54;
      recv_idle_pct = 30;
    end else begin
      send_idle_pct = 0;
      recv_idle_pct = 0;
    end
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    cur_typed        = typed;
    cur_want         = want;
    in_valid_i      <= 1'b1;
    in_word_i.func   <= f;
    in_word_i.symbol <= s;
    do @(posedge clk_i); while (!in_ready_o);
    words_sent++;
    @(negedge clk_i);
  endtask

  task automatic send_op(input func_e f, input logic [7:0] s);
    send_word(f, s, 1'b0, '0);
  endtask

  function automatic dir_row_t make_row(func_e f, logic [7:0] s, bit typed,
                                        logic [LEN_BITS-1:0] len, status_e st);
    dir_row_t row;
    row.func   = f;
    row.symbol = s;
    row.typed  = typed;
    row.want   = '{match_now: 1'b0, found: 1'b0, pattern_length: len, status: st};
    return row;
  endfunction

  // Fills the pattern to capacity with a periodic sequence, pushes past it,
  // then scans text of the same period so that the long pattern can match.
  task automatic full_fill_seq();
    logic [7:0] alph [4];
    int         period;
    int         tlen;
    period = $urandom_range(1, 4);
    for (int i = 0; i < 4; i++) alph[i] = 8'($urandom_range(0, 255));
    send_op(FUNC_CLEAR, 8'($urandom_range(0, 255)));
    for (int i = 0; i < MAX_PATTERN; i++) send_op(FUNC_APPEND, alph[i % period]);
    repeat ($urandom_range(1, 3)) send_op(FUNC_APPEND, 8'($urandom_range(0, 255)));
    tlen = MAX_PATTERN + $urandom_range(0, 8);
    for (int k = 0; k < tlen; k++) begin
      if ($urandom_range(0, 99) < 4) send_op(FUNC_TEXT, 8'($urandom_range(0, 255)));
      else send_op(FUNC_TEXT, alph[k % period]);
    end
    send_op(FUNC_SEARCH, 8'($urandom_range(0, 255)));
    for (int k = 0; k < MAX_PATTERN; k++) send_op(FUNC_TEXT, alph[k % period]);
  endtask

  // Short pattern over a small alphabet, then text drawn from that alphabet.
  task automatic short_pattern_seq();
    logic [7:0] alph [3];
    logic [7:0] pat [8];
    int         nalph;
    int         plen;
    int         tlen;
    int         r;
    nalph = $urandom_range(2, 3);
    plen  = $urandom_range(1, 8);
    tlen  = $urandom_range(8, 30);
    for (int i = 0; i < 3; i++) alph[i] = 8'($urandom_range(0, 255));
    for (int i = 0; i < plen; i++) pat[i] = alph[$urandom_range(0, nalph - 1)];
    send_op(FUNC_CLEAR, 8'($urandom_range(0, 255)));
    for (int i = 0; i < plen; i++) send_op(FUNC_APPEND, pat[i]);
    for (int k = 0; k < tlen; k++) begin
      r = $urandom_range(0, 99);
      if (r < 20) begin
        for (int i = 0; i < plen; i++) send_op(FUNC_TEXT, pat[i]);
        if ($urandom_range(0, 1)) send_op(FUNC_SEARCH, 8'($urandom_range(0, 255)));
      end else if (r < 25) begin
        send_op(FUNC_SEARCH, 8'($urandom_range(0, 255)));
      end else if (r < 28) begin
        send_op(FUNC_APPEND, alph[$urandom_range(0, nalph - 1)]);
      end else if (r < 31) begin
        send_op(FUNC_TEXT, 8'($urandom_range(0, 255)));
      end else begin
        send_op(FUNC_TEXT, alph[$urandom_range(0, nalph - 1)]);
      end
    end
  endtask

  // Main stimulus.
  initial begin
    dir_row_t dir_rows [$];
    dir_row_t row;
    int       kind;
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    in_word_i   = '0;
    out_ready_i = 1'b0;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed words: empty pattern, controls, extreme symbols, a failure walk
    // and an append in the middle of a search.
    dir_rows.push_back(make_row(FUNC_TEXT,   8'hA5, 1'b1, 7'd0, STAT_EMPTY));
    dir_rows.push_back(make_row(FUNC_SEARCH, 8'h00, 1'b1, 7'd0, STAT_OK));
    dir_rows.push_back(make_row(FUNC_CLEAR,  8'hFF, 1'b1, 7'd0, STAT_OK));
    dir_rows.push_back(make_row(FUNC_APPEND, 8'h00, 1'b1, 7'd1, STAT_OK));
    dir_rows.push_back(make_row(FUNC_APPEND, 8'hFF, 1'b1, 7'd2, STAT_OK));
    dir_rows.push_back(make_row(FUNC_APPEND, 8'h00, 1'b1, 7'd3, STAT_OK));
    dir_rows.push_back(make_row(FUNC_TEXT,   8'hFF, 1'b0, 7'd0, STAT_OK));
    dir_rows.push_back(make_row(FUNC_TEXT,   8'h00, 1'b0, 7'd0, STAT_OK));
    dir_rows.push_back(make_row(FUNC_TEXT,   8'hFF, 1'b0, 7'd0, STAT_OK));
    dir_rows.push_back(make_row(FUNC_TEXT,   8'h00, 1'b0, 7'd0, STAT_OK));
    dir_rows.push_back(make_row(FUNC_TEXT,   8'h00, 1'b0, 7'd0, STAT_OK));
    dir_rows.push_back(make_row(FUNC_SEARCH, 8'h3C, 1'b1, 7'd3, STAT_OK));
    dir_rows.push_back(make_row(FUNC_TEXT,   8'h00, 1'b0, 7'd0, STAT_OK));
    dir_rows.push_back(make_row(FUNC_TEXT,   8'hFF, 1'b0, 7'd0, STAT_OK));
    dir_rows.push_back(make_row(FUNC_APPEND, 8'hFF, 1'b0, 7'd0, STAT_OK));
    dir_rows.push_back(make_row(FUNC_TEXT,   8'h00, 1'b0, 7'd0, STAT_OK));
    dir_rows.push_back(make_row(FUNC_TEXT,   8'hFF, 1'b0, 7'd0, STAT_OK));
    dir_rows.push_back(make_row(FUNC_SEARCH, 8'hC3, 1'b1, 7'd4, STAT_OK));
    dir_rows.push_back(make_row(FUNC_TEXT,   8'h00, 1'b0, 7'd0, STAT_OK));
    dir_rows.push_back(make_row(FUNC_TEXT,   8'h00, 1'b0, 7'd0, STAT_OK));
    dir_rows.push_back(make_row(FUNC_TEXT,   8'hFF, 1'b0, 7'd0, STAT_OK));
    dir_rows.push_back(make_row(FUNC_TEXT,   8'h00, 1'b0, 7'd0, STAT_OK));
    dir_rows.push_back(make_row(FUNC_TEXT,   8'hFF, 1'b0, 7'd0, STAT_OK));
    dir_rows.push_back(make_row(FUNC_CLEAR,  8'h81, 1'b1, 7'd0, STAT_OK));
    dir_rows.push_back(make_row(FUNC_TEXT,   8'h5A, 1'b1, 7'd0, STAT_EMPTY));
    foreach (dir_rows[i]) begin
      row = dir_rows[i];
      send_word(row.func, row.symbol, row.typed, row.want);
    end

    // Random part: mostly well-formed pattern and text runs, some noise.
    full_fill_seq();
    while (words_sent < WORD_TARGET) begin
      kind = $urandom_range(0, 99);
      if (kind < 6) begin
        full_fill_seq();
      end else if (kind < 82) begin
        short_pattern_seq();
      end else begin
        repeat ($urandom_range(1, 10))
          send_op(func_e'($urandom_range(0, 3)), 8'($urandom_range(0, 255)));
      end
    end
    in_valid_i <= 1'b0;

    while (pending_results.size() != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
    if (err_cnt == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

[sim.f]
src/kmp_pkg.sv
src/kmp_ram.sv
src/kmp_ctrl.sv
src/kmp_stream_matcher_top.sv
tb/kmp_stream_matcher_top_test.sv
